/* rtl/ffpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared constants and types for the first-fit partition allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    // Table geometry
    localparam int PARTITIONS = 8;
    localparam int ADDR_BITS  = 16;
    localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

    // Fixed field widths of the channels
    localparam int MODE_W  = 1;
    localparam int INDEX_W = 3;
    localparam int FIELD_W = 16;
    localparam int REQ_W   = 16;

    // Size of an entry needs one bit above the address
    localparam int SIZE_W = ADDR_BITS + 1;
    localparam int CMP_W  = (SIZE_W > REQ_W) ? SIZE_W : REQ_W;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD     = 1'b0;
    localparam logic [MODE_W-1:0] MODE_ALLOCATE = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // take the accepted item, restart the scan
        logic scan_adv;  // step to the next entry
        logic hit;       // record a fit on the current entry
        logic commit;    // write back the grant and load the result
    } ffpa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fit;       // current entry is free and large enough
        logic last;      // current entry is the last of the table
        logic out_free;  // result register can take a new result
    } ffpa_status_t;

endpackage

/* rtl/ffpa_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_in_if / ffpa_out_if
// Valid/ready channels for allocator items and results.
// ----------------------------------------------------------------------------
interface ffpa_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [2:0]  entry_index;
    logic [15:0] entry_first;
    logic [15:0] entry_last;
    logic        entry_available;
    logic [15:0] request_blocks;

    modport source (
        output valid, mode, entry_index, entry_first, entry_last,
               entry_available, request_blocks,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, entry_first, entry_last,
               entry_available, request_blocks,
        output ready
    );
endinterface

interface ffpa_out_if;
    logic        valid;
    logic        ready;
    logic        granted;
    logic [15:0] start_address;
    logic [2:0]  chosen_partition;

    modport source (
        output valid, granted, start_address, chosen_partition,
        input  ready
    );
    modport sink (
        input  valid, granted, start_address, chosen_partition,
        output ready
    );
endinterface

/* rtl/ffpa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Sequencer: accepts an item, steps the first-fit scan, commits the result.
// ----------------------------------------------------------------------------
module ffpa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_mode,
    output logic                  in_ready,
    input  ffpa_pkg::ffpa_status_t status,
    output ffpa_pkg::ffpa_cmd_t    cmd
);
    import ffpa_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Decide commands and next state
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (in_mode == MODE_ALLOCATE) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (status.fit)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (status.last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/ffpa_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_datapath
// Partition table, scan counter, fit check, write-back and result register.
// ----------------------------------------------------------------------------
module ffpa_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ffpa_pkg::ffpa_cmd_t    cmd,
    output ffpa_pkg::ffpa_status_t status,
    input  logic                   in_mode,
    input  logic [2:0]             in_entry_index,
    input  logic [15:0]            in_entry_first,
    input  logic [15:0]            in_entry_last,
    input  logic                   in_entry_available,
    input  logic [15:0]            in_request_blocks,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_granted,
    output logic [15:0]            out_start_address,
    output logic [2:0]             out_chosen_partition
);
    import ffpa_pkg::*;

    // Table storage: bounds in memory, free flags in flip-flops
    logic [ADDR_BITS-1:0] first_mem [PARTITIONS];
    logic [ADDR_BITS-1:0] last_mem  [PARTITIONS];
    logic [PARTITIONS-1:0] avail_reg;

    logic [ADDR_BITS-1:0] rd_first_reg;
    logic [ADDR_BITS-1:0] rd_last_reg;
    logic [IDX_W-1:0]     rd_addr;

    logic [IDX_W-1:0]     cnt_reg;
    logic [REQ_W-1:0]     req_reg;
    logic                 grant_reg;
    logic [ADDR_BITS-1:0] start_reg;
    logic [ADDR_BITS-1:0] new_first_reg;
    logic                 exact_reg;

    logic                 out_valid_reg;
    logic                 out_granted_reg;
    logic [15:0]          out_start_reg;
    logic [2:0]           out_chosen_reg;

    logic                 load_en;
    logic [SIZE_W-1:0]    size;
    logic [CMP_W-1:0]     size_ext;
    logic [CMP_W-1:0]     req_ext;

    // Pick the read address for the next entry
    always_comb
    begin
        if (cmd.capture)
            rd_addr = '0;
        else if (cmd.scan_adv)
            rd_addr = IDX_W'(cnt_reg + 1'b1);
        else
            rd_addr = cnt_reg;
    end

    assign load_en = cmd.capture && (in_mode == MODE_LOAD) &&
                     (32'(in_entry_index) < PARTITIONS);

    // Write and read the bounds memory
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            first_mem[IDX_W'(in_entry_index)] <= ADDR_BITS'(in_entry_first);
            last_mem[IDX_W'(in_entry_index)]  <= ADDR_BITS'(in_entry_last);
        end
        else if (cmd.commit && grant_reg)
        begin
            first_mem[cnt_reg] <= new_first_reg;
        end
        rd_first_reg <= first_mem[rd_addr];
        rd_last_reg  <= last_mem[rd_addr];
    end

    // Size of the current entry, zero when the bounds cross
    always_comb
    begin
        if (rd_last_reg < rd_first_reg)
            size = '0;
        else
            size = SIZE_W'({1'b0, rd_last_reg} - {1'b0, rd_first_reg} + 1'b1);
        size_ext = CMP_W'(size);
        req_ext  = CMP_W'(req_reg);
    end

    assign status.fit      = avail_reg[cnt_reg] && (req_ext <= size_ext);
    assign status.last     = (32'(cnt_reg) == PARTITIONS - 1);
    assign status.out_free = !out_valid_reg || out_ready;

    // Free flags: load writes, exact fit clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            avail_reg <= '0;
        else if (load_en)
            avail_reg[IDX_W'(in_entry_index)] <= in_entry_available;
        else if (cmd.commit && grant_reg && exact_reg)
            avail_reg[cnt_reg] <= 1'b0;
    end

    // Scan counter and grant flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            grant_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            cnt_reg   <= '0;
            grant_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= rd_addr;
            if (cmd.hit)
                grant_reg <= 1'b1;
        end
    end

    // Hold the request and the winning entry's figures
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= in_request_blocks;
        if (cmd.hit)
        begin
            start_reg     <= rd_first_reg;
            new_first_reg <= ADDR_BITS'(rd_first_reg + ADDR_BITS'(req_reg));
            exact_reg     <= (req_ext == size_ext);
        end
    end

    // Result register valid: set on commit, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_granted_reg <= grant_reg;
            out_start_reg   <= grant_reg ? 16'(start_reg) : 16'd0;
            out_chosen_reg  <= grant_reg ? 3'(cnt_reg) : 3'd0;
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_granted          = out_granted_reg;
    assign out_start_address    = out_start_reg;
    assign out_chosen_partition = out_chosen_reg;

endmodule

/* rtl/first_fit_partition_allocator_top.sv */
`timescale 1ns / 1ps
// Sequence: a load item is captured and then committed to the result register; an
// allocate item is captured, scans 1 to PARTITIONS entries, then is committed.
// The scan walks one table entry a cycle through the registered memory read.
// Items are handled one at a time; the next item is taken once the previous
// result sits in the output register. Reset clears all free flags at once.
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_top
// First-fit partition allocator: loads table entries and grants block ranges.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_top (
    input logic        clk,
    input logic        rst_n,
    ffpa_in_if.sink    req_ch,
    ffpa_out_if.source rsp_ch
);
    import ffpa_pkg::*;

    ffpa_cmd_t    cmd;
    ffpa_status_t status;

    // Sequencer
    ffpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_ch.valid),
        .in_mode  (req_ch.mode),
        .in_ready (req_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table and result path
    ffpa_datapath u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .in_mode              (req_ch.mode),
        .in_entry_index       (req_ch.entry_index),
        .in_entry_first       (req_ch.entry_first),
        .in_entry_last        (req_ch.entry_last),
        .in_entry_available   (req_ch.entry_available),
        .in_request_blocks    (req_ch.request_blocks),
        .out_valid            (rsp_ch.valid),
        .out_ready            (rsp_ch.ready),
        .out_granted          (rsp_ch.granted),
        .out_start_address    (rsp_ch.start_address),
        .out_chosen_partition (rsp_ch.chosen_partition)
    );

endmodule

/* tb/first_fit_partition_allocator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_top_tb
// Drives load and allocate items into the partition allocator and checks
// every result against a first-fit model of the partition table kept here.
// A directed sequence covers the corner cases first. Random traffic follows,
// with random idling on both channels, one long output stall and drain
// pauses between phases.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator_top_tb;

    import ffpa_pkg::*;

    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] index;
        logic [FIELD_W-1:0] first;
        logic [FIELD_W-1:0] last;
        logic               avail;
        logic [REQ_W-1:0]   blocks;
    } alloc_item_t;

    typedef struct packed {
        logic               granted;
        logic [FIELD_W-1:0] start;
        logic [INDEX_W-1:0] part;
    } grant_t;

    logic clk;
    logic rst_n;

    ffpa_in_if  req_ch ();
    ffpa_out_if rsp_ch ();

    first_fit_partition_allocator_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch),
        .rsp_ch (rsp_ch)
    );

    // Partition table as the allocator should hold it
    logic [ADDR_BITS-1:0] tbl_first [PARTITIONS];
    logic [ADDR_BITS-1:0] tbl_last  [PARTITIONS];
    bit                   tbl_free  [PARTITIONS];

    alloc_item_t pending_items [$];
    grant_t      expected_grants [$];

    bit in_taken;
    int items_taken;
    int errors;
    int out_stall_left;
    bit out_stall_done;

    // Generate the clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Apply reset once and hold every input at a known value
    initial
    begin
        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.mode            = MODE_LOAD;
        req_ch.entry_index     = '0;
        req_ch.entry_first     = '0;
        req_ch.entry_last      = '0;
        req_ch.entry_available = 1'b0;
        req_ch.request_blocks  = '0;
        rsp_ch.ready           = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        for (int k = 0; k < PARTITIONS; k++)
        begin
            tbl_first[k] = '0;
            tbl_last[k]  = '0;
            tbl_free[k]  = 1'b0;
        end
    end

    // Work out the result of one item and update the table
    function automatic grant_t allocate_first_fit(alloc_item_t it);
        grant_t            g;
        logic [SIZE_W-1:0] span;
        bit                found;
        g     = '0;
        found = 1'b0;
        if (it.mode == MODE_LOAD)
        begin
            if (int'(it.index) < PARTITIONS)
            begin
                tbl_first[it.index] = it.first[ADDR_BITS-1:0];
                tbl_last[it.index]  = it.last[ADDR_BITS-1:0];
                tbl_free[it.index]  = it.avail;
            end
        end
        else
        begin
            for (int k = 0; k < PARTITIONS; k++)
            begin
                if (!found && tbl_free[k])
                begin
                    if (tbl_last[k] < tbl_first[k])
                        span = '0;
                    else
                        span = {1'b0, tbl_last[k]} - {1'b0, tbl_first[k]} + 1'b1;
                    if (it.blocks <= span)
                    begin
                        found     = 1'b1;
                        g.granted = 1'b1;
                        g.start   = tbl_first[k];
                        g.part    = INDEX_W'(k);
                        if (it.blocks == span)
                            tbl_free[k] = 1'b0;
                        tbl_first[k] = tbl_first[k] + it.blocks;
                    end
                end
            end
        end
        return g;
    endfunction

    // Queue a load item; the request field carries noise
    task automatic push_load(input int idx, input int first, input int last,
                             input bit avail);
        alloc_item_t it;
        it.mode   = MODE_LOAD;
        it.index  = INDEX_W'(idx);
        it.first  = FIELD_W'(first);
        it.last   = FIELD_W'(last);
        it.avail  = avail;
        it.blocks = REQ_W'($urandom);
        pending_items.push_back(it);
    endtask

    // Queue an allocate item; the entry fields carry noise
    task automatic push_alloc(input int blocks);
        alloc_item_t it;
        it.mode   = MODE_ALLOCATE;
        it.index  = INDEX_W'($urandom);
        it.first  = FIELD_W'($urandom);
        it.last   = FIELD_W'($urandom);
        it.avail  = 1'($urandom);
        it.blocks = REQ_W'(blocks);
        pending_items.push_back(it);
    endtask

    // Mostly small partitions and requests so that entries drain to exact fits
    task automatic push_random(input int count);
        int first;
        int sel;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 25)
            begin
                first = $urandom_range(0, 65535);
                sel   = $urandom_range(0, 99);
                if (sel < 70)
                    push_load($urandom_range(0, 7), first,
                              first + $urandom_range(1, 48) - 1,
                              $urandom_range(0, 99) < 85);
                else if (sel < 85)
                    push_load($urandom_range(0, 7), first, $urandom_range(0, 65535),
                              $urandom_range(0, 99) < 85);
                else
                    push_load($urandom_range(0, 7), $urandom_range(0, 1023),
                              $urandom_range(65000, 65535), $urandom_range(0, 99) < 85);
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    push_alloc($urandom_range(0, 8));
                else if (sel < 80)
                    push_alloc($urandom_range(0, 48));
                else if (sel < 90)
                    push_alloc(0);
                else
                    push_alloc($urandom_range(0, 65535));
            end
        end
    endtask

    // Hold until every queued item has gone in and every result has come out
    task automatic wait_drained();
        while (pending_items.size() != 0 || req_ch.valid || expected_grants.size() != 0)
            @(posedge clk);
    endtask

    // Drive the input channel from the queue of pending items
    always @(negedge clk)
    begin
        alloc_item_t it;
        bit          calm;
        calm = (items_taken >= 300 && items_taken < 420);
        if (rst_n && (!req_ch.valid || in_taken))
        begin
            in_taken = 1'b0;
            if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 9))
            begin
                it = pending_items.pop_front();
                req_ch.mode            <= it.mode;
                req_ch.entry_index     <= it.index;
                req_ch.entry_first     <= it.first;
                req_ch.entry_last      <= it.last;
                req_ch.entry_available <= it.avail;
                req_ch.request_blocks  <= it.blocks;
                req_ch.valid           <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Predict the result of each input transfer
    always @(posedge clk)
    begin
        alloc_item_t it;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            it.mode   = req_ch.mode;
            it.index  = req_ch.entry_index;
            it.first  = req_ch.entry_first;
            it.last   = req_ch.entry_last;
            it.avail  = req_ch.entry_available;
            it.blocks = req_ch.request_blocks;
            expected_grants.push_back(allocate_first_fit(it));
            in_taken    = 1'b1;
            items_taken = items_taken + 1;
        end
    end

    // Drive ready: random idling plus one long stall to back the block up
    always @(negedge clk)
    begin
        bit calm;
        calm = (items_taken >= 300 && items_taken < 420);
        if (rst_n)
        begin
            if (!out_stall_done && items_taken >= 100)
            begin
                out_stall_done = 1'b1;
                out_stall_left = 300;
            end
            if (out_stall_left > 0)
            begin
                out_stall_left = out_stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    // Compare each output transfer with the oldest prediction
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_grants.size() == 0)
            begin
                $display("%0t: unexpected result granted=%0b start=%h part=%0d", $time,
                         rsp_ch.granted, rsp_ch.start_address, rsp_ch.chosen_partition);
                errors = errors + 1;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (rsp_ch.granted !== want.granted)
                begin
                    $display("%0t: granted expected %0b actual %0b", $time,
                             want.granted, rsp_ch.granted);
                    errors = errors + 1;
                end
                if (rsp_ch.start_address !== want.start)
                begin
                    $display("%0t: start_address expected %h actual %h", $time,
                             want.start, rsp_ch.start_address);
                    errors = errors + 1;
                end
                if (rsp_ch.chosen_partition !== want.part)
                begin
                    $display("%0t: chosen_partition expected %0d actual %0d", $time,
                             want.part, rsp_ch.chosen_partition);
                    errors = errors + 1;
                end
            end
        end
    end

    // Stimulus: directed corners, then two random phases with drain pauses
    initial
    begin
        in_taken       = 1'b0;
        items_taken    = 0;
        errors         = 0;
        out_stall_left = 0;
        out_stall_done = 1'b0;

        // nothing free after reset
        push_alloc(0);
        push_alloc(16'hFFFF);
        // full range entry: largest request, zero request, then wrap past the top
        push_load(0, 16'h0000, 16'hFFFF, 1'b1);
        push_alloc(16'hFFFF);
        push_alloc(0);
        push_alloc(1);
        push_alloc(1);
        // inverted entry has size zero: only a zero request fits, exactly
        push_load(7, 16'h8000, 16'h7FFF, 1'b1);
        push_alloc(2);
        push_alloc(0);
        // used entry is skipped, free one fits exactly
        push_load(2, 16'h0010, 16'h001F, 1'b0);
        push_load(5, 16'h0100, 16'h0103, 1'b1);
        push_alloc(5);
        push_alloc(4);
        // single block at the top wraps to zero
        push_load(1, 16'hFFFF, 16'hFFFF, 1'b1);
        push_alloc(1);
        // remaining entries, first fit over several candidates
        push_load(3, 16'h5555, 16'hAAAA, 1'b1);
        push_load(4, 16'hAAAA, 16'hFFFE, 1'b1);
        push_load(6, 16'h0000, 16'h0000, 1'b1);
        push_alloc(16'h5556);
        push_alloc(16'h5555);
        push_alloc(1);
        push_alloc(16'h8001);
        wait_drained();

        push_random(340);
        wait_drained();

        push_random(340);
        wait_drained();

        // let any stray result show up
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* first_fit_partition_allocator_top.f */
rtl/ffpa_pkg.sv
rtl/ffpa_if.sv
rtl/ffpa_ctrl.sv
rtl/ffpa_datapath.sv
rtl/first_fit_partition_allocator_top.sv
tb/first_fit_partition_allocator_top_tb.sv
